@@ rtl/global_sequence_alignment_unit_macros.svh @@
// Assertion macros for the global sequence alignment unit.
`ifndef GLOBAL_SEQUENCE_ALIGNMENT_UNIT_MACROS_SVH
`define GLOBAL_SEQUENCE_ALIGNMENT_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define GSAU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GSAU_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GSAU_ASSERT(label, prop, msg)
`define GSAU_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

@@ rtl/gsau_pkg.sv @@
// Package with types, constants and helpers of the global sequence alignment unit.
`timescale 1ns / 1ps
package gsau_pkg;

    localparam int MAX_LEN   = 32;
    localparam int TABLE_DIM = MAX_LEN + 1;
    localparam int TBL_DEPTH = TABLE_DIM * TABLE_DIM;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);
    localparam int COL_DEPTH = 2 * MAX_LEN;
    localparam int COL_AW    = $clog2(COL_DEPTH);
    localparam int LEN_W     = $clog2(MAX_LEN + 1);
    localparam int POS_W     = $clog2(COL_DEPTH + 2);
    localparam int STORE_AW  = $clog2(MAX_LEN);
    localparam int PEN_W     = 14;
    localparam int SYM_W     = 8;

    localparam logic [SYM_W-1:0] GAP_SYMBOL = 8'd95;
    localparam logic [7:0] MISMATCH_RESET = 8'd3;
    localparam logic [7:0] GAP_RESET      = 8'd2;

    typedef enum logic [1:0] {
        OP_PUSH_FIRST  = 2'd0,
        OP_PUSH_SECOND = 2'd1,
        OP_RUN         = 2'd2,
        OP_UNUSED      = 2'd3
    } op_t;

    typedef enum logic {
        REG_MISMATCH = 1'b0,
        REG_GAP      = 1'b1
    } reg_index_t;

    // Penalty of k gaps; k never exceeds MAX_LEN + 1, so the product fits.
    function automatic logic [PEN_W-1:0] gap_mult(input logic [LEN_W-1:0] k,
                                                  input logic [7:0] g);
        logic [PEN_W-1:0] p;
        p = PEN_W'(k) * PEN_W'(g);
        return p;
    endfunction

    // Table address of row r, column c.
    function automatic logic [TBL_AW-1:0] tbl_addr(input logic [LEN_W-1:0] r,
                                                   input logic [LEN_W-1:0] c);
        logic [TBL_AW-1:0] a;
        a = TBL_AW'(r) * TBL_AW'(TABLE_DIM) + TBL_AW'(c);
        return a;
    endfunction

endpackage

@@ rtl/gsau_if.sv @@
// Channel interfaces of the global sequence alignment unit.
`timescale 1ns / 1ps
interface gsau_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] symbol;
    modport source (output valid, output op, output symbol, input ready);
    modport sink (input valid, input op, input symbol, output ready);
endinterface

interface gsau_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  first_symbol;
    logic [7:0]  second_symbol;
    logic [13:0] total_penalty;
    logic        last_column;
    modport source (output valid, output first_symbol, output second_symbol,
                    output total_penalty, output last_column, input ready);
    modport sink (input valid, input first_symbol, input second_symbol,
                  input total_penalty, input last_column, output ready);
endinterface

interface gsau_cfg_if;
    logic       valid;
    logic       ready;
    logic       index;
    logic [7:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/gsau_ram.sv @@
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module gsau_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

@@ rtl/global_sequence_alignment_unit.sv @@
// Top level of the global sequence alignment unit.
// Usage: symbols are pushed on in_ch with op 0 (first sequence) or op 1 (second
// sequence), one transfer per cycle while idle; pushes past 32 symbols are
// dropped. Op 2 starts a run; op 3 is dropped. cfg writes index 0 (mismatch
// penalty) or 1 (gap penalty) and is always ready; write it only while the
// unit is idle. A run fills the m x n penalty table in the table RAM cell by
// cell, each cell a read of the upper cell, then compute and write. Traceback
// then makes three table reads per diagonal or gap step and writes the padding
// columns, all into a column buffer RAM. Columns leave out_ch one per transfer;
// a stalled receiver holds the output register and the emit sequencer waits.
// in_ch is ready only when no run is in progress. The last column carries
// last_column; a run with nothing left after trimming emits one gap/gap
// column. Both lengths clear when a run is accepted. Reset clears the lengths
// and sets the penalties to 3 and 2; the RAMs need no clearing since every
// entry read in a run is written in that run.
`timescale 1ns / 1ps
`include "global_sequence_alignment_unit_macros.svh"
module global_sequence_alignment_unit (
    input  logic              clk,
    input  logic              rst_n,
    gsau_in_if.sink           in_ch,
    gsau_out_if.source        out_ch,
    gsau_cfg_if.sink          cfg
);
    localparam int LW = gsau_pkg::LEN_W;
    localparam int PW = gsau_pkg::POS_W;
    localparam int NW = gsau_pkg::PEN_W;

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_F_RD   = 13'b0000000000010,
        S_F_WR   = 13'b0000000000100,
        S_TOT_RD = 13'b0000000001000,
        S_TOT_WR = 13'b0000000010000,
        S_T_R0   = 13'b0000000100000,
        S_T_R1   = 13'b0000001000000,
        S_T_R2   = 13'b0000010000000,
        S_T_R3   = 13'b0000100000000,
        S_PAD    = 13'b0001000000000,
        S_E_ST   = 13'b0010000000000,
        S_E_RD   = 13'b0100000000000,
        S_E_LD   = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;
    logic [7:0] mis_reg, gap_reg;
    logic [LW-1:0] first_len_reg, first_len_next, second_len_reg, second_len_next;
    logic [LW-1:0] m_reg, m_next, n_reg, n_next, i_reg, i_next, j_reg, j_next;
    logic [PW-1:0] l_reg, l_next, pos_reg, pos_next, start_reg, start_next;
    logic [PW-1:0] a_reg, a_next;
    logic trim_reg, trim_next;
    logic [NW-1:0] left_reg, left_next, diag_reg, diag_next, here_reg, here_next;
    logic [NW-1:0] total_reg, total_next;
    logic [LW-1:0] rd_row_reg, rd_col_reg, rd_row, rd_col;
    logic [7:0] first_store_reg [gsau_pkg::MAX_LEN];
    logic [7:0] second_store_reg [gsau_pkg::MAX_LEN];

    logic out_valid_reg, out_valid_next, out_last_reg, out_last_next;
    logic [7:0] out_x_reg, out_x_next, out_y_reg, out_y_next;
    logic [NW-1:0] out_pen_reg, out_pen_next;

    logic tbl_we;
    logic [gsau_pkg::TBL_AW-1:0] tbl_waddr;
    logic [NW-1:0] tbl_wdata, tbl_rdata, tval;
    logic col_we;
    logic [gsau_pkg::COL_AW-1:0] col_waddr, col_raddr;
    logic [15:0] col_wdata, col_rdata;

    logic in_xfer;
    logic [7:0] sx, sy, col_x, col_y;
    logic eq;
    logic [NW:0] s_diag, s_up, s_left, vmin;
    logic slot_free;

    gsau_ram #(.WIDTH(NW), .DEPTH(gsau_pkg::TBL_DEPTH)) u_tbl (
        .clk(clk), .wr_en(tbl_we), .wr_addr(tbl_waddr), .wr_data(tbl_wdata),
        .rd_addr(gsau_pkg::tbl_addr(rd_row, rd_col)), .rd_data(tbl_rdata)
    );

    gsau_ram #(.WIDTH(16), .DEPTH(gsau_pkg::COL_DEPTH)) u_cols (
        .clk(clk), .wr_en(col_we), .wr_addr(col_waddr), .wr_data(col_wdata),
        .rd_addr(col_raddr), .rd_data(col_rdata)
    );

    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_xfer     = in_ch.valid && in_ch.ready;
    assign cfg.ready   = 1'b1;

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.first_symbol  = out_x_reg;
    assign out_ch.second_symbol = out_y_reg;
    assign out_ch.total_penalty = out_pen_reg;
    assign out_ch.last_column   = out_last_reg;
    assign slot_free = !out_valid_reg || out_ch.ready;

    // Table borders are never stored; they follow from the gap penalty.
    assign tval = (rd_row_reg == '0) ? gsau_pkg::gap_mult(rd_col_reg, gap_reg) :
                  (rd_col_reg == '0) ? gsau_pkg::gap_mult(rd_row_reg, gap_reg) :
                  tbl_rdata;

    assign sx = first_store_reg[gsau_pkg::STORE_AW'(i_reg - LW'(1))];
    assign sy = second_store_reg[gsau_pkg::STORE_AW'(j_reg - LW'(1))];
    assign eq = (sx == sy);

    always_comb
    begin
        s_diag = {1'b0, diag_reg} + (NW+1)'(mis_reg);
        s_up   = {1'b0, tval} + (NW+1)'(gap_reg);
        s_left = {1'b0, left_reg} + (NW+1)'(gap_reg);
        if (s_diag <= s_up && s_diag <= s_left)
        begin
            vmin = s_diag;
        end
        else if (s_up <= s_diag && s_up <= s_left)
        begin
            vmin = s_up;
        end
        else
        begin
            vmin = s_left;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        first_len_next  = first_len_reg;
        second_len_next = second_len_reg;
        m_next = m_reg;  n_next = n_reg;  i_next = i_reg;  j_next = j_reg;
        l_next = l_reg;  pos_next = pos_reg;  start_next = start_reg;
        a_next = a_reg;  trim_next = trim_reg;
        left_next = left_reg;  diag_next = diag_reg;  here_next = here_reg;
        total_next = total_reg;
        rd_row = rd_row_reg;  rd_col = rd_col_reg;
        tbl_we = 1'b0;  tbl_waddr = gsau_pkg::tbl_addr(i_reg, j_reg);
        tbl_wdata = vmin[NW-1:0];
        col_we = 1'b0;  col_x = gsau_pkg::GAP_SYMBOL;  col_y = gsau_pkg::GAP_SYMBOL;
        col_raddr = gsau_pkg::COL_AW'(a_reg - PW'(1));
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_x_next = out_x_reg;  out_y_next = out_y_reg;
        out_pen_next = out_pen_reg;  out_last_next = out_last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer && in_ch.op == gsau_pkg::OP_PUSH_FIRST &&
                    first_len_reg < LW'(gsau_pkg::MAX_LEN))
                begin
                    first_len_next = first_len_reg + LW'(1);
                end
                if (in_xfer && in_ch.op == gsau_pkg::OP_PUSH_SECOND &&
                    second_len_reg < LW'(gsau_pkg::MAX_LEN))
                begin
                    second_len_next = second_len_reg + LW'(1);
                end
                if (in_xfer && in_ch.op == gsau_pkg::OP_RUN)
                begin
                    m_next = first_len_reg;
                    n_next = second_len_reg;
                    l_next = PW'(first_len_reg) + PW'(second_len_reg);
                    first_len_next  = '0;
                    second_len_next = '0;
                    trim_next  = 1'b0;
                    start_next = PW'(1);
                    i_next = LW'(1);
                    j_next = LW'(1);
                    left_next = gsau_pkg::gap_mult(LW'(1), gap_reg);
                    diag_next = '0;
                    if (first_len_reg != '0 && second_len_reg != '0)
                    begin
                        state_next = S_F_RD;
                    end
                    else
                    begin
                        state_next = S_TOT_RD;
                    end
                end
            end
            S_F_RD:
            begin
                rd_row = i_reg - LW'(1);
                rd_col = j_reg;
                state_next = S_F_WR;
            end
            S_F_WR:
            begin
                tbl_we = 1'b1;
                if (eq)
                begin
                    tbl_wdata = diag_reg;
                end
                left_next = tbl_wdata;
                diag_next = tval;
                if (j_reg == n_reg)
                begin
                    j_next    = LW'(1);
                    i_next    = i_reg + LW'(1);
                    left_next = gsau_pkg::gap_mult(i_reg + LW'(1), gap_reg);
                    diag_next = gsau_pkg::gap_mult(i_reg, gap_reg);
                    state_next = (i_reg == m_reg) ? S_TOT_RD : S_F_RD;
                end
                else
                begin
                    j_next = j_reg + LW'(1);
                    state_next = S_F_RD;
                end
            end
            S_TOT_RD:
            begin
                rd_row = m_reg;
                rd_col = n_reg;
                state_next = S_TOT_WR;
            end
            S_TOT_WR:
            begin
                total_next = tval;
                i_next   = m_reg;
                j_next   = n_reg;
                pos_next = l_reg;
                if (m_reg != '0 && n_reg != '0)
                begin
                    state_next = S_T_R0;
                end
                else if (l_reg != '0)
                begin
                    state_next = S_PAD;
                end
                else
                begin
                    state_next = S_E_ST;
                end
            end
            S_T_R0:
            begin
                rd_row = i_reg;
                rd_col = j_reg;
                state_next = S_T_R1;
            end
            S_T_R1:
            begin
                here_next = tval;
                rd_row = i_reg - LW'(1);
                rd_col = j_reg - LW'(1);
                state_next = S_T_R2;
            end
            S_T_R2:
            begin
                diag_next = tval;
                rd_row = i_reg - LW'(1);
                rd_col = j_reg;
                state_next = S_T_R3;
            end
            S_T_R3:
            begin
                col_we = 1'b1;
                if (eq || s_diag == {1'b0, here_reg})
                begin
                    col_x = sx;
                    col_y = sy;
                    i_next = i_reg - LW'(1);
                    j_next = j_reg - LW'(1);
                end
                else if (s_up == {1'b0, here_reg})
                begin
                    col_x = sx;
                    i_next = i_reg - LW'(1);
                end
                else
                begin
                    col_y = sy;
                    j_next = j_reg - LW'(1);
                end
                pos_next = pos_reg - PW'(1);
                if (i_next != '0 && j_next != '0)
                begin
                    state_next = S_T_R0;
                end
                else
                begin
                    state_next = (pos_next != '0) ? S_PAD : S_E_ST;
                end
            end
            S_PAD:
            begin
                col_we = 1'b1;
                if (i_reg != '0)
                begin
                    col_x = sx;
                    i_next = i_reg - LW'(1);
                end
                if (j_reg != '0)
                begin
                    col_y = sy;
                    j_next = j_reg - LW'(1);
                end
                pos_next = pos_reg - PW'(1);
                if (pos_reg == PW'(1))
                begin
                    state_next = S_E_ST;
                end
            end
            S_E_ST:
            begin
                if (start_reg > l_reg)
                begin
                    if (slot_free)
                    begin
                        out_valid_next = 1'b1;
                        out_x_next = gsau_pkg::GAP_SYMBOL;
                        out_y_next = gsau_pkg::GAP_SYMBOL;
                        out_pen_next = total_reg;
                        out_last_next = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    a_next = start_reg;
                    state_next = S_E_RD;
                end
            end
            S_E_RD:
            begin
                if (slot_free)
                begin
                    state_next = S_E_LD;
                end
            end
            S_E_LD:
            begin
                out_valid_next = 1'b1;
                out_x_next = col_rdata[15:8];
                out_y_next = col_rdata[7:0];
                out_pen_next = total_reg;
                out_last_next = (a_reg == l_reg);
                if (a_reg == l_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    a_next = a_reg + PW'(1);
                    state_next = S_E_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // The highest all-gap column marks the end of the leading padding.
        if (col_we && !trim_reg && col_x == gsau_pkg::GAP_SYMBOL &&
            col_y == gsau_pkg::GAP_SYMBOL)
        begin
            trim_next  = 1'b1;
            start_next = pos_reg + PW'(1);
        end
    end

    assign col_waddr = gsau_pkg::COL_AW'(pos_reg - PW'(1));
    assign col_wdata = {col_x, col_y};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            first_len_reg  <= '0;
            second_len_reg <= '0;
            out_valid_reg  <= 1'b0;
            mis_reg        <= gsau_pkg::MISMATCH_RESET;
            gap_reg        <= gsau_pkg::GAP_RESET;
            trim_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            first_len_reg  <= first_len_next;
            second_len_reg <= second_len_next;
            out_valid_reg  <= out_valid_next;
            trim_reg       <= trim_next;
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    gsau_pkg::REG_MISMATCH: mis_reg <= cfg.data;
                    gsau_pkg::REG_GAP:      gap_reg <= cfg.data;
                    default:                mis_reg <= mis_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg <= m_next;  n_reg <= n_next;  i_reg <= i_next;  j_reg <= j_next;
        l_reg <= l_next;  pos_reg <= pos_next;  start_reg <= start_next;
        a_reg <= a_next;
        left_reg <= left_next;  diag_reg <= diag_next;  here_reg <= here_next;
        total_reg <= total_next;
        rd_row_reg <= rd_row;  rd_col_reg <= rd_col;
        out_x_reg <= out_x_next;  out_y_reg <= out_y_next;
        out_pen_reg <= out_pen_next;  out_last_reg <= out_last_next;
        if (in_xfer && in_ch.op == gsau_pkg::OP_PUSH_FIRST &&
            first_len_reg < LW'(gsau_pkg::MAX_LEN))
        begin
            first_store_reg[gsau_pkg::STORE_AW'(first_len_reg)] <= in_ch.symbol;
        end
        if (in_xfer && in_ch.op == gsau_pkg::OP_PUSH_SECOND &&
            second_len_reg < LW'(gsau_pkg::MAX_LEN))
        begin
            second_store_reg[gsau_pkg::STORE_AW'(second_len_reg)] <= in_ch.symbol;
        end
    end

    `GSAU_ASSERT(a_fill_bounds, (state_reg == S_F_WR) |-> (i_reg != '0 && i_reg <= m_reg && j_reg != '0 && j_reg <= n_reg), "fill cell outside the table")
    `GSAU_ASSERT(a_run_clears, (in_xfer && in_ch.op == gsau_pkg::OP_RUN) |=> (first_len_reg == '0 && second_len_reg == '0), "lengths not cleared by a run")
    `GSAU_ASSERT(a_pad_pos, (state_reg == S_PAD || state_reg == S_T_R3) |-> (pos_reg != '0), "column written below position one")
    `GSAU_ASSERT_ALWAYS(a_len_max, (first_len_reg <= LW'(gsau_pkg::MAX_LEN)) && (second_len_reg <= LW'(gsau_pkg::MAX_LEN)), "sequence length beyond the store")

endmodule

@@ verif/tb_global_sequence_alignment_unit_if.sv @@
// Shared types of the testbench for the global sequence alignment unit.
`timescale 1ns / 1ps
package tb_gsau_types_pkg;

    typedef struct packed {
        logic [7:0]  first_symbol;
        logic [7:0]  second_symbol;
        logic [13:0] total_penalty;
        logic        last_column;
    } column_t;
endpackage

@@ verif/tb_top.sv @@
// Top-level testbench of the global sequence alignment unit with a built-in alignment predictor.
`timescale 1ns / 1ps
module tb_top;

    logic clk;
    logic rst_n;

    gsau_in_if  in_ch ();
    gsau_out_if out_ch ();
    gsau_cfg_if cfg ();

    global_sequence_alignment_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source),
        .cfg    (cfg.sink)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Predictor state.
    logic [7:0]  seq_a [gsau_pkg::MAX_LEN];
    logic [7:0]  seq_b [gsau_pkg::MAX_LEN];
    int          len_a;
    int          len_b;
    logic [7:0]  cost_mismatch;
    logic [7:0]  cost_gap;
    tb_gsau_types_pkg::column_t expected_columns [$];

    int  error_count;
    bit  sink_noisy;
    bit  source_noisy;
    bit  sink_hold;

    task automatic report_mismatch(input string what);
        error_count++;
        $display("%0t mismatch: %s", $realtime, what);
    endtask

    // Computes the alignment of the pushed sequences and queues its columns.
    function automatic void predict_alignment();
        int          dp [gsau_pkg::MAX_LEN+1][gsau_pkg::MAX_LEN+1];
        logic [7:0]  cx [2*gsau_pkg::MAX_LEN+1];
        logic [7:0]  cy [2*gsau_pkg::MAX_LEN+1];
        int          i, j, v, d, u, l, here, pos, total, start, cols;
        tb_gsau_types_pkg::column_t c;
        cols = len_a + len_b;
        for (i = 0; i <= len_a; i++)
            dp[i][0] = (i * cost_gap) & 16'h3FFF;
        for (j = 0; j <= len_b; j++)
            dp[0][j] = (j * cost_gap) & 16'h3FFF;
        for (i = 1; i <= len_a; i++)
        begin
            for (j = 1; j <= len_b; j++)
            begin
                if (seq_a[i-1] == seq_b[j-1])
                    v = dp[i-1][j-1];
                else
                begin
                    d = dp[i-1][j-1] + cost_mismatch;
                    u = dp[i-1][j] + cost_gap;
                    l = dp[i][j-1] + cost_gap;
                    v = d;
                    if (u < v) v = u;
                    if (l < v) v = l;
                end
                dp[i][j] = v & 16'h3FFF;
            end
        end
        total = dp[len_a][len_b];
        pos = cols;
        i = len_a;
        j = len_b;
        while (i > 0 && j > 0)
        begin
            here = dp[i][j];
            if (seq_a[i-1] == seq_b[j-1] || dp[i-1][j-1] + cost_mismatch == here)
            begin
                cx[pos] = seq_a[i-1];
                cy[pos] = seq_b[j-1];
                i--;
                j--;
            end
            else if (dp[i-1][j] + cost_gap == here)
            begin
                cx[pos] = seq_a[i-1];
                cy[pos] = gsau_pkg::GAP_SYMBOL;
                i--;
            end
            else
            begin
                cx[pos] = gsau_pkg::GAP_SYMBOL;
                cy[pos] = seq_b[j-1];
                j--;
            end
            pos--;
        end
        while (pos > 0)
        begin
            if (i > 0) begin i--; cx[pos] = seq_a[i]; end
            else cx[pos] = gsau_pkg::GAP_SYMBOL;
            if (j > 0) begin j--; cy[pos] = seq_b[j]; end
            else cy[pos] = gsau_pkg::GAP_SYMBOL;
            pos--;
        end
        // Everything up to the last all-gap column is padding and gets dropped.
        start = 1;
        for (pos = cols; pos >= 1; pos--)
        begin
            if (cx[pos] == gsau_pkg::GAP_SYMBOL && cy[pos] == gsau_pkg::GAP_SYMBOL)
            begin
                start = pos + 1;
                break;
            end
        end
        if (start > cols)
        begin
            c.first_symbol = gsau_pkg::GAP_SYMBOL;
            c.second_symbol = gsau_pkg::GAP_SYMBOL;
            c.total_penalty = total[13:0];
            c.last_column = 1'b1;
            expected_columns.push_back(c);
        end
        else
        begin
            for (pos = start; pos <= cols; pos++)
            begin
                c.first_symbol = cx[pos];
                c.second_symbol = cy[pos];
                c.total_penalty = total[13:0];
                c.last_column = (pos == cols);
                expected_columns.push_back(c);
            end
        end
        len_a = 0;
        len_b = 0;
    endfunction

    function automatic void predict_item(input gsau_pkg::op_t op, input logic [7:0] sym);
        case (op)
            gsau_pkg::OP_PUSH_FIRST:
                if (len_a < gsau_pkg::MAX_LEN) begin seq_a[len_a] = sym; len_a++; end
            gsau_pkg::OP_PUSH_SECOND:
                if (len_b < gsau_pkg::MAX_LEN) begin seq_b[len_b] = sym; len_b++; end
            gsau_pkg::OP_RUN:
                predict_alignment();
            default: ;
        endcase
    endfunction

    // Valid stays high after a transfer so that items can follow back to back;
    // wait_idle drops it.
    task automatic send_item(input gsau_pkg::op_t op, input logic [7:0] sym);
        while (source_noisy && $urandom_range(99) < 9)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.op <= op;
        in_ch.symbol <= sym;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predict_item(op, sym);
        @(negedge clk);
    endtask

    task automatic write_register(input gsau_pkg::reg_index_t idx, input logic [7:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        if (idx == gsau_pkg::REG_MISMATCH)
            cost_mismatch = value;
        else
            cost_gap = value;
        @(negedge clk);
        cfg.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (expected_columns.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic send_sequences(input int na, input int nb, input int alphabet);
        int k;
        for (k = 0; k < na || k < nb; k++)
        begin
            if (k < na) send_item(gsau_pkg::OP_PUSH_FIRST, 8'($urandom_range(alphabet)));
            if (k < nb) send_item(gsau_pkg::OP_PUSH_SECOND, 8'($urandom_range(alphabet)));
        end
    endtask

    task automatic test_directed();
        int k;
        send_item(gsau_pkg::OP_RUN, 8'd0);
        send_item(gsau_pkg::OP_PUSH_FIRST, 8'd0);
        send_item(gsau_pkg::OP_PUSH_SECOND, 8'd255);
        send_item(gsau_pkg::OP_UNUSED, 8'd7);
        send_item(gsau_pkg::OP_RUN, 8'hAA);
        send_item(gsau_pkg::OP_PUSH_FIRST, 8'd65);
        send_item(gsau_pkg::OP_PUSH_FIRST, 8'd66);
        send_item(gsau_pkg::OP_PUSH_SECOND, 8'd65);
        send_item(gsau_pkg::OP_RUN, 8'h55);
        // A pushed underscore behaves as a gap and triggers the padding trim.
        send_item(gsau_pkg::OP_PUSH_FIRST, gsau_pkg::GAP_SYMBOL);
        send_item(gsau_pkg::OP_PUSH_SECOND, gsau_pkg::GAP_SYMBOL);
        send_item(gsau_pkg::OP_RUN, 8'd0);
        send_item(gsau_pkg::OP_PUSH_FIRST, 8'd1);
        send_item(gsau_pkg::OP_RUN, 8'd0);
        send_item(gsau_pkg::OP_PUSH_SECOND, 8'd2);
        send_item(gsau_pkg::OP_RUN, 8'd0);
        wait_idle();
        // Full stores: the pushes past the limit are dropped.
        for (k = 0; k < gsau_pkg::MAX_LEN + 2; k++)
            send_item(gsau_pkg::OP_PUSH_FIRST, 8'($urandom_range(3)));
        for (k = 0; k < gsau_pkg::MAX_LEN + 2; k++)
            send_item(gsau_pkg::OP_PUSH_SECOND, 8'($urandom_range(3)));
        send_item(gsau_pkg::OP_RUN, 8'd0);
        wait_idle();
    endtask

    task automatic test_random(input int runs);
        int r, na, nb;
        for (r = 0; r < runs; r++)
        begin
            na = ($urandom_range(9) == 0) ? $urandom_range(gsau_pkg::MAX_LEN + 1) :
                                            $urandom_range(6);
            nb = ($urandom_range(9) == 0) ? $urandom_range(gsau_pkg::MAX_LEN + 1) :
                                            $urandom_range(6);
            send_sequences(na, nb, ($urandom_range(1)) ? 255 : 3);
            if ($urandom_range(9) == 0) send_item(gsau_pkg::OP_UNUSED, 8'($urandom));
            if ($urandom_range(4) == 0)
                send_item(gsau_pkg::OP_PUSH_FIRST, gsau_pkg::GAP_SYMBOL);
            send_item(gsau_pkg::OP_RUN, 8'($urandom));
        end
        wait_idle();
    endtask

    task automatic test_backpressure();
        int k;
        sink_hold = 1'b1;
        for (k = 0; k < 3; k++)
        begin
            send_sequences(4, 5, 3);
            send_item(gsau_pkg::OP_RUN, 8'd0);
        end
        wait_idle();
    endtask

    // Long receiver hold-off counted in cycles.
    always @(posedge clk)
    begin : hold_counter
        int cnt;
        if (!sink_hold)
            cnt = 0;
        else if (++cnt >= 400)
            sink_hold = 1'b0;
    end

    // Receiver: drives ready and checks each accepted column.
    always @(negedge clk)
        out_ch.ready <= !sink_hold && !(sink_noisy && $urandom_range(99) < 9);

    always @(posedge clk)
    begin
        tb_gsau_types_pkg::column_t got, want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = {out_ch.first_symbol, out_ch.second_symbol,
                   out_ch.total_penalty, out_ch.last_column};
            if (expected_columns.size() == 0)
                report_mismatch($sformatf("unexpected column %h", got));
            else
            begin
                want = expected_columns.pop_front();
                if (got.first_symbol !== want.first_symbol)
                    report_mismatch($sformatf("first_symbol %h want %h",
                        got.first_symbol, want.first_symbol));
                if (got.second_symbol !== want.second_symbol)
                    report_mismatch($sformatf("second_symbol %h want %h",
                        got.second_symbol, want.second_symbol));
                if (got.total_penalty !== want.total_penalty)
                    report_mismatch($sformatf("total_penalty %0d want %0d",
                        got.total_penalty, want.total_penalty));
                if (got.last_column !== want.last_column)
                    report_mismatch($sformatf("last_column %b want %b",
                        got.last_column, want.last_column));
            end
        end
    end

    initial
    begin
        #5000000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        error_count = 0;
        len_a = 0;
        len_b = 0;
        cost_mismatch = gsau_pkg::MISMATCH_RESET;
        cost_gap = gsau_pkg::GAP_RESET;
        sink_noisy = 1'b0;
        source_noisy = 1'b0;
        sink_hold = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.op = gsau_pkg::OP_PUSH_FIRST;
        in_ch.symbol = 8'd0;
        cfg.valid = 1'b0;
        cfg.index = gsau_pkg::REG_MISMATCH;
        cfg.data = 8'd0;
        out_ch.ready = 1'b0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        sink_noisy = 1'b1;
        source_noisy = 1'b1;
        test_random(4);
        write_register(gsau_pkg::REG_MISMATCH, 8'd0);
        write_register(gsau_pkg::REG_GAP, 8'd255);
        test_random(3);
        write_register(gsau_pkg::REG_MISMATCH, 8'd255);
        write_register(gsau_pkg::REG_GAP, 8'd0);
        test_random(3);
        write_register(gsau_pkg::REG_MISMATCH, 8'($urandom));
        write_register(gsau_pkg::REG_GAP, 8'($urandom));
        test_backpressure();
        test_random(3);
        write_register(gsau_pkg::REG_MISMATCH, 8'd1);
        write_register(gsau_pkg::REG_GAP, 8'd1);
        test_random(3);
        wait_idle();

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
